// ===== rtl/prq_pkg.sv =====
// Shared constants and codes for the priority ready-queue scheduler.
package prq_pkg;

  // Default sizes
  localparam int MAX_TASKS_DEF   = 16;
  localparam int PRIO_LEVELS_DEF = 32;

  // Width used to compare task ids and counts up to 32
  localparam int ID_EXT_W = 6;

  // Command codes
  localparam logic [2:0] CMD_CREATE   = 3'd0;
  localparam logic [2:0] CMD_SCHEDULE = 3'd1;
  localparam logic [2:0] CMD_TICK     = 3'd2;
  localparam logic [2:0] CMD_SLEEP    = 3'd3;
  localparam logic [2:0] CMD_BLOCK    = 3'd4;
  localparam logic [2:0] CMD_UNBLOCK  = 3'd5;

  // Status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_BAD_ID = 2'd2;

  // Task states
  typedef enum logic [2:0] {
    TS_UNUSED   = 3'd0,
    TS_READY    = 3'd1,
    TS_RUNNING  = 3'd2,
    TS_SLEEPING = 3'd3,
    TS_BLOCKED  = 3'd4
  } task_state_t;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

// ===== rtl/prq_alu.sv =====
// Shared 32-bit add/subtract unit for tick, deadline and wake tests.
module prq_alu (
  input  prq_pkg::alu_op_t op,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic [31:0]      y,
  output logic             neg
);

  // Wrapping add or subtract; neg is the top bit of the result
  always_comb begin
    case (op)
      prq_pkg::ALU_ADD: y = a + b;
      prq_pkg::ALU_SUB: y = a - b;
      default:          y = a + b;
    endcase
    neg = y[31];
  end

endmodule

// ===== rtl/priority_ready_queue_scheduler_core.sv =====
// Top level of the priority ready-queue task scheduler.
//
// Usage: drive cmd, task_id, priority_req and duration_ms and raise start
// while busy is low; the request is taken at that clock edge. busy stays high
// until the result has been shown. The result (running_id, switch_pending,
// status, new_task_id, now_ms, ready_mask) is valid for exactly one cycle
// while done is high; the receiver cannot stall it and must take it then.
// cfg_write with cfg_data sets enabled; write it only while idle.
//
// Steps after a request is taken: a disabled tick, an empty schedule, a
// refused sleep or block and an unused code go straight to the result;
// create and unblock pass through S_CREATE or S_UNBLOCK; an enabled tick
// increments the tick count in S_TICK_INC and then sweeps one slot a cycle
// through the shared adder in S_SWEEP; sleep and block walk the priority
// list one link a cycle in S_WALK, unlink a found task in S_FIN and park
// it in S_PARK; schedule scans the ready bitmap one priority a cycle from
// the top in S_SCAN and rotates the chosen list in S_ROT. One request is in
// flight at a time; the next one is taken once busy falls after the result.
//
// Reset (rst, synchronous): the idle task sits alone in the priority 0 list,
// the tick count is zero, the scheduler is disabled and the block is idle.
module priority_ready_queue_scheduler_core #(
  parameter int MAX_TASKS       = prq_pkg::MAX_TASKS_DEF,
  parameter int PRIORITY_LEVELS = prq_pkg::PRIO_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [3:0]  task_id,
  input  logic [4:0]  priority_req,
  input  logic [31:0] duration_ms,
  input  logic        cfg_write,
  input  logic        cfg_data,
  output logic        done,
  output logic [3:0]  running_id,
  output logic        switch_pending,
  output logic [1:0]  status,
  output logic [3:0]  new_task_id,
  output logic [31:0] now_ms,
  output logic [31:0] ready_mask
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int LW = TW + 1;
  localparam int CW = TW + 1;
  localparam int PW = $clog2(PRIORITY_LEVELS);
  localparam int XW = prq_pkg::ID_EXT_W;
  localparam logic [LW-1:0] LINK_NIL = {LW{1'b1}};
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_TASKS);
  localparam logic [PW-1:0] TOP_PRIO = PW'(PRIORITY_LEVELS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CREATE, S_SCAN, S_ROT, S_TICK_INC, S_SWEEP,
    S_REM_START, S_WALK, S_FIN, S_PARK, S_UNBLOCK, S_DONE
  } seq_state_t;

  seq_state_t state;

  // Scheduler state
  logic                        enabled;
  logic [PRIORITY_LEVELS-1:0]  ready_bits;
  logic [TW-1:0]               list_head [PRIORITY_LEVELS];
  logic [TW-1:0]               list_tail [PRIORITY_LEVELS];
  logic [LW-1:0]               next_link [MAX_TASKS];
  logic [PW-1:0]               task_prio [MAX_TASKS];
  prq_pkg::task_state_t        task_state [MAX_TASKS];
  logic [31:0]                 wake_deadline [MAX_TASKS];
  logic [CW-1:0]               task_count;
  logic [TW-1:0]               current_task;
  logic [31:0]                 tick_count;

  // Request and working registers
  logic [2:0]    cmd_r;
  logic [3:0]    tid_r;
  logic [4:0]    preq_r;
  logic [31:0]   dur_r;
  logic [PW-1:0] cur_prio;
  logic          pend;
  logic [1:0]    status_r;
  logic [TW-1:0] new_id_r;
  logic [PW-1:0] scan_p;
  logic [CW-1:0] idx;
  logic [LW-1:0] walk_cur;
  logic [LW-1:0] walk_prev;
  logic [CW-1:0] walk_n;

  // Shared adder
  prq_pkg::alu_op_t alu_op;
  logic [31:0]      alu_a, alu_b, alu_y;
  logic             alu_neg;

  prq_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .y   (alu_y),
    .neg (alu_neg)
  );

  // Derived request values
  logic [PW-1:0] clamp_prio;
  logic [XW-1:0] tid_ext;
  logic [TW-1:0] tid_idx;
  logic          tid_ok;
  logic [LW-1:0] cur_link;
  logic [TW-1:0] rot_head;
  logic [LW-1:0] rot_next;

  always_comb begin
    if (XW'(preq_r) > XW'(PRIORITY_LEVELS - 1)) clamp_prio = TOP_PRIO;
    else clamp_prio = PW'(preq_r);
    tid_ext  = XW'(tid_r);
    tid_idx  = tid_ext[TW-1:0];
    tid_ok   = (tid_ext < XW'(task_count)) &&
               ((task_state[tid_idx] == prq_pkg::TS_BLOCKED) ||
                (task_state[tid_idx] == prq_pkg::TS_SLEEPING));
    cur_link = {1'b0, current_task};
    rot_head = list_head[scan_p];
    rot_next = next_link[rot_head];
  end

  // Adder operands by step
  always_comb begin
    alu_op = prq_pkg::ALU_ADD;
    alu_a  = tick_count;
    alu_b  = 32'd1;
    case (state)
      S_SWEEP: begin
        alu_op = prq_pkg::ALU_SUB;
        alu_b  = wake_deadline[idx[TW-1:0]];
      end
      S_PARK:  alu_b = dur_r;
      default: alu_b = 32'd1;
    endcase
  end

  // Insert-at-tail request for the ready lists
  logic          add_en;
  logic [TW-1:0] add_t;
  logic [PW-1:0] add_p;

  always_comb begin
    add_en = 1'b0;
    add_t  = idx[TW-1:0];
    add_p  = task_prio[idx[TW-1:0]];
    case (state)
      S_CREATE: begin
        add_en = task_count < MAX_CNT;
        add_t  = task_count[TW-1:0];
        add_p  = clamp_prio;
      end
      S_SWEEP: begin
        add_en = (idx < task_count) &&
                 (task_state[idx[TW-1:0]] == prq_pkg::TS_SLEEPING) && !alu_neg;
      end
      S_UNBLOCK: begin
        add_en = tid_ok;
        add_t  = tid_idx;
        add_p  = task_prio[tid_idx];
      end
      default: add_en = 1'b0;
    endcase
  end

  // Sequencer and scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      enabled      <= 1'b0;
      ready_bits   <= PRIORITY_LEVELS'(1);
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        list_head[i] <= '0;
        list_tail[i] <= '0;
      end
      for (int i = 0; i < MAX_TASKS; i++) begin
        next_link[i]  <= LINK_NIL;
        task_prio[i]  <= '0;
        task_state[i] <= prq_pkg::TS_UNUSED;
      end
      task_state[0] <= prq_pkg::TS_READY;
      task_count    <= CW'(1);
      current_task  <= '0;
      tick_count    <= '0;
      pend          <= 1'b0;
      status_r      <= prq_pkg::STAT_OK;
      new_id_r      <= '0;
    end else begin
      if (cfg_write) enabled <= cfg_data;
      done <= 1'b0;

      // Append a task to the tail of its priority list
      if (add_en) begin
        task_state[add_t] <= prq_pkg::TS_READY;
        next_link[add_t]  <= LINK_NIL;
        if (!ready_bits[add_p]) list_head[add_p] <= add_t;
        else next_link[list_tail[add_p]] <= {1'b0, add_t};
        list_tail[add_p]  <= add_t;
        ready_bits[add_p] <= 1'b1;
        if (add_p > cur_prio) pend <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r    <= cmd;
            tid_r    <= task_id;
            preq_r   <= priority_req;
            dur_r    <= duration_ms;
            cur_prio <= task_prio[current_task];
            pend     <= 1'b0;
            status_r <= prq_pkg::STAT_OK;
            new_id_r <= '0;
            case (cmd)
              prq_pkg::CMD_CREATE: state <= S_CREATE;
              prq_pkg::CMD_SCHEDULE: begin
                scan_p <= TOP_PRIO;
                if (ready_bits == '0) begin
                  state <= S_DONE;
                  done  <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              prq_pkg::CMD_TICK: begin
                if (enabled) begin
                  state <= S_TICK_INC;
                end else begin
                  state <= S_DONE;
                  done  <= 1'b1;
                end
              end
              prq_pkg::CMD_SLEEP, prq_pkg::CMD_BLOCK: begin
                if (task_state[current_task] == prq_pkg::TS_READY ||
                    task_state[current_task] == prq_pkg::TS_RUNNING) begin
                  state <= S_REM_START;
                end else begin
                  status_r <= prq_pkg::STAT_BAD_ID;
                  state    <= S_DONE;
                  done     <= 1'b1;
                end
              end
              prq_pkg::CMD_UNBLOCK: state <= S_UNBLOCK;
              default: begin
                state <= S_DONE;
                done  <= 1'b1;
              end
            endcase
          end
        end

        // New task takes the next free slot
        S_CREATE: begin
          if (task_count < MAX_CNT) begin
            task_prio[task_count[TW-1:0]] <= clamp_prio;
            new_id_r   <= task_count[TW-1:0];
            task_count <= task_count + CW'(1);
          end else begin
            status_r <= prq_pkg::STAT_FULL;
          end
          state <= S_DONE;
          done  <= 1'b1;
        end

        // Find the highest ready priority, one bit a cycle
        S_SCAN: begin
          if (scan_p == '0 || ready_bits[scan_p]) state <= S_ROT;
          else scan_p <= scan_p - PW'(1);
        end

        // Rotate the chosen list and run its head
        S_ROT: begin
          if (task_state[current_task] == prq_pkg::TS_RUNNING)
            task_state[current_task] <= prq_pkg::TS_READY;
          if (!rot_next[TW]) begin
            list_head[scan_p] <= rot_next[TW-1:0];
            next_link[rot_head] <= LINK_NIL;
            next_link[list_tail[scan_p]] <= {1'b0, rot_head};
            list_tail[scan_p] <= rot_head;
          end
          current_task <= rot_head;
          task_state[rot_head] <= prq_pkg::TS_RUNNING;
          state <= S_DONE;
          done  <= 1'b1;
        end

        S_TICK_INC: begin
          tick_count <= alu_y;
          idx        <= '0;
          state      <= S_SWEEP;
        end

        // Wake sleepers, one slot a cycle
        S_SWEEP: begin
          if (idx < task_count) begin
            idx <= idx + CW'(1);
          end else begin
            pend  <= 1'b1;
            state <= S_DONE;
            done  <= 1'b1;
          end
        end

        S_REM_START: begin
          walk_cur  <= {1'b0, list_head[cur_prio]};
          walk_prev <= LINK_NIL;
          walk_n    <= '0;
          if (ready_bits[cur_prio]) state <= S_WALK;
          else state <= S_PARK;
        end

        // Walk the list to find the current task
        S_WALK: begin
          if (walk_n < MAX_CNT && walk_cur != cur_link) begin
            if (walk_cur[TW]) begin
              state <= S_PARK;
            end else begin
              walk_prev <= walk_cur;
              walk_cur  <= next_link[walk_cur[TW-1:0]];
              walk_n    <= walk_n + CW'(1);
            end
          end else if (walk_cur != cur_link) begin
            state <= S_PARK;
          end else begin
            state <= S_FIN;
          end
        end

        // Unlink the current task
        S_FIN: begin
          if (walk_prev[TW]) list_head[cur_prio] <= next_link[current_task][TW-1:0];
          else next_link[walk_prev[TW-1:0]] <= next_link[current_task];
          if (list_tail[cur_prio] == current_task)
            list_tail[cur_prio] <= walk_prev[TW-1:0];
          next_link[current_task] <= LINK_NIL;
          if (walk_prev[TW] && next_link[current_task][TW])
            ready_bits[cur_prio] <= 1'b0;
          state <= S_PARK;
        end

        S_PARK: begin
          if (cmd_r == prq_pkg::CMD_SLEEP) begin
            wake_deadline[current_task] <= alu_y;
            task_state[current_task]    <= prq_pkg::TS_SLEEPING;
          end else begin
            task_state[current_task] <= prq_pkg::TS_BLOCKED;
          end
          pend  <= 1'b1;
          state <= S_DONE;
          done  <= 1'b1;
        end

        S_UNBLOCK: begin
          if (!tid_ok) status_r <= prq_pkg::STAT_BAD_ID;
          state <= S_DONE;
          done  <= 1'b1;
        end

        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result ports
  logic [XW-1:0] run_ext, new_ext;
  always_comb begin
    run_ext = XW'(current_task);
    new_ext = XW'(new_id_r);
  end

  assign busy           = (state != S_IDLE);
  assign running_id     = run_ext[3:0];
  assign new_task_id    = new_ext[3:0];
  assign switch_pending = pend;
  assign status         = status_r;
  assign now_ms         = tick_count;
  assign ready_mask     = 32'(ready_bits);

  // Checks
  a_done_in_done_state: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_DONE)) else $error("done outside result cycle");
  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("not idle after result");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (task_count <= MAX_CNT) && (task_count != '0)) else $error("task count out of range");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status != 2'd3)) else $error("bad status code");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the priority ready-queue scheduler core.
`timescale 1ns / 1ps

module testbench;

  localparam int NTASK = 16;
  localparam int NPRIO = 32;
  localparam logic [7:0] NIL = 8'hFF;
  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic [2:0]  cmd;
    logic [3:0]  tid;
    logic [4:0]  preq;
    logic [31:0] dur;
  } request_t;

  typedef struct {
    logic [3:0]  run_id;
    logic        sw_pend;
    logic [1:0]  stat;
    logic [3:0]  new_id;
    logic [31:0] now;
    logic [31:0] rmask;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] cmd = '0;
  logic [3:0] task_id = '0;
  logic [4:0] priority_req = '0;
  logic [31:0] duration_ms = '0;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;
  logic busy, done, switch_pending;
  logic [3:0] running_id, new_task_id;
  logic [1:0] status;
  logic [31:0] now_ms, ready_mask;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int issued = 0;
  int quiet = 0;

  // Scheduler mirror state
  logic [7:0]  lhead[NPRIO];
  logic [7:0]  ltail[NPRIO];
  logic [7:0]  nlink[NTASK];
  logic [4:0]  tprio[NTASK];
  prq_pkg::task_state_t tstate[NTASK];
  logic [31:0] deadline[NTASK];
  logic [31:0] rbits;
  logic [31:0] ticks;
  int          tcount;
  int          cur;
  logic        sched_en;
  logic        pend;

  priority_ready_queue_scheduler_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .task_id(task_id), .priority_req(priority_req), .duration_ms(duration_ms),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .done(done),
    .running_id(running_id), .switch_pending(switch_pending), .status(status),
    .new_task_id(new_task_id), .now_ms(now_ms), .ready_mask(ready_mask)
  );

  always #1 clk = ~clk;

  // Append a task to the tail of its priority list
  task automatic enqueue_ready(input int t);
    int p;
    p = tprio[t];
    tstate[t] = prq_pkg::TS_READY;
    nlink[t] = NIL;
    if (!rbits[p]) lhead[p] = 8'(t);
    else if (ltail[p] < NTASK) nlink[ltail[p]] = 8'(t);
    ltail[p] = 8'(t);
    rbits[p] = 1'b1;
    if (p > tprio[cur]) pend = 1'b1;
  endtask

  // Unlink a task from its priority list
  task automatic dequeue_ready(input int t);
    int p, c, prev, n;
    p = tprio[t];
    prev = NIL;
    if (!rbits[p]) return;
    c = lhead[p];
    for (n = 0; n < NTASK && c != t; n++) begin
      if (c >= NTASK) return;
      prev = c;
      c = nlink[c];
    end
    if (c != t) return;
    if (prev == NIL) lhead[p] = nlink[t];
    else nlink[prev] = nlink[t];
    if (ltail[p] == t) ltail[p] = 8'(prev);
    nlink[t] = NIL;
    if (prev == NIL && lhead[p] == NIL) rbits[p] = 1'b0;
  endtask

  task automatic mirror_reset();
    rbits = '0;
    for (int i = 0; i < NPRIO; i++) begin
      lhead[i] = NIL;
      ltail[i] = NIL;
    end
    for (int i = 0; i < NTASK; i++) begin
      nlink[i] = NIL;
      tprio[i] = '0;
      tstate[i] = prq_pkg::TS_UNUSED;
      deadline[i] = '0;
    end
    tcount = 1;
    cur = 0;
    ticks = '0;
    sched_en = 1'b0;
    enqueue_ready(0);
    pend = 1'b0;
  endtask

  // Apply one request to the mirror and queue its outcome
  task automatic predict_outcome(input request_t r);
    outcome_t o;
    int p, h, nx, id;
    logic [1:0] stat;
    logic [3:0] nid;
    logic [31:0] age;
    stat = prq_pkg::STAT_OK;
    nid = '0;
    pend = 1'b0;
    case (r.cmd)
      prq_pkg::CMD_CREATE: begin
        if (tcount >= NTASK) stat = prq_pkg::STAT_FULL;
        else begin
          id = tcount;
          tcount++;
          tprio[id] = r.preq;
          deadline[id] = '0;
          enqueue_ready(id);
          nid = 4'(id);
        end
      end
      prq_pkg::CMD_SCHEDULE: begin
        if (rbits != 0) begin
          p = NPRIO - 1;
          while (p > 0 && !rbits[p]) p--;
          if (tstate[cur] == prq_pkg::TS_RUNNING) tstate[cur] = prq_pkg::TS_READY;
          h = lhead[p];
          if (h < NTASK) begin
            nx = nlink[h];
            if (nx < NTASK) begin
              lhead[p] = 8'(nx);
              nlink[h] = NIL;
              if (ltail[p] < NTASK) nlink[ltail[p]] = 8'(h);
              ltail[p] = 8'(h);
            end
            cur = h;
            tstate[h] = prq_pkg::TS_RUNNING;
          end
        end
      end
      prq_pkg::CMD_TICK: begin
        if (sched_en) begin
          ticks++;
          for (int i = 0; i < tcount; i++) begin
            age = ticks - deadline[i];
            if (tstate[i] == prq_pkg::TS_SLEEPING && !age[31])
              enqueue_ready(i);
          end
          pend = 1'b1;
        end
      end
      prq_pkg::CMD_SLEEP, prq_pkg::CMD_BLOCK: begin
        if (tstate[cur] == prq_pkg::TS_READY || tstate[cur] == prq_pkg::TS_RUNNING) begin
          dequeue_ready(cur);
          if (r.cmd == prq_pkg::CMD_SLEEP) begin
            deadline[cur] = ticks + r.dur;
            tstate[cur] = prq_pkg::TS_SLEEPING;
          end else tstate[cur] = prq_pkg::TS_BLOCKED;
          pend = 1'b1;
        end else stat = prq_pkg::STAT_BAD_ID;
      end
      prq_pkg::CMD_UNBLOCK: begin
        if (r.tid < tcount &&
            (tstate[r.tid] == prq_pkg::TS_BLOCKED || tstate[r.tid] == prq_pkg::TS_SLEEPING))
          enqueue_ready(r.tid);
        else stat = prq_pkg::STAT_BAD_ID;
      end
      default: ;
    endcase
    o.run_id = 4'(cur);
    o.sw_pend = pend;
    o.stat = stat;
    o.new_id = nid;
    o.now = ticks;
    o.rmask = rbits;
    expected_outcomes.push_back(o);
  endtask

  // Request driver
  always @(posedge clk) begin
    logic launch;
    request_t r;
    launch = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        predict_outcome(pending_reqs.pop_front());
        issued++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 &&
            ((issued >= 400 && issued < 600) || $urandom_range(99) >= 24))
          launch = 1'b1;
      end else launch = 1'b1;
      if (launch) begin
        r = pending_reqs[0];
        cmd <= r.cmd;
        task_id <= r.tid;
        priority_req <= r.preq;
        duration_ms <= r.dur;
      end
      start <= launch;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result exp none got running_id=%0d", $time, running_id);
        errors++;
      end else begin
        e = expected_outcomes.pop_front();
        if (running_id !== e.run_id) begin
          $display("%0t: running_id exp %0d got %0d", $time, e.run_id, running_id);
          errors++;
        end
        if (switch_pending !== e.sw_pend) begin
          $display("%0t: switch_pending exp %0d got %0d", $time, e.sw_pend,
                   switch_pending);
          errors++;
        end
        if (status !== e.stat) begin
          $display("%0t: status exp %0d got %0d", $time, e.stat, status);
          errors++;
        end
        if (new_task_id !== e.new_id) begin
          $display("%0t: new_task_id exp %0d got %0d", $time, e.new_id, new_task_id);
          errors++;
        end
        if (now_ms !== e.now) begin
          $display("%0t: now_ms exp %h got %h", $time, e.now, now_ms);
          errors++;
        end
        if (ready_mask !== e.rmask) begin
          $display("%0t: ready_mask exp %h got %h", $time, e.rmask, ready_mask);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_req(input logic [2:0] c, input logic [3:0] t,
                          input logic [4:0] p, input logic [31:0] d);
    request_t r;
    r.cmd = c;
    r.tid = t;
    r.preq = p;
    r.dur = d;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || start || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (NTASK + 10) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    sched_en = v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly meaningful commands with random content
  task automatic push_random(input int n);
    int k;
    logic [31:0] d;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      d = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(6));
      if (k < 8) push_req(prq_pkg::CMD_CREATE, 4'($urandom), 5'($urandom), $urandom());
      else if (k < 38)
        push_req(prq_pkg::CMD_SCHEDULE, 4'($urandom), 5'($urandom), $urandom());
      else if (k < 60) push_req(prq_pkg::CMD_TICK, 4'($urandom), 5'($urandom), $urandom());
      else if (k < 72) push_req(prq_pkg::CMD_SLEEP, 4'($urandom), 5'($urandom), d);
      else if (k < 80) push_req(prq_pkg::CMD_BLOCK, 4'($urandom), 5'($urandom), $urandom());
      else if (k < 97)
        push_req(prq_pkg::CMD_UNBLOCK, 4'($urandom), 5'($urandom), $urandom());
      else push_req(3'($urandom_range(6, 7)), 4'($urandom), 5'($urandom), $urandom());
    end
  endtask

  initial begin
    mirror_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_enable(1'b0);

    // Idle task blocked: nothing ready, then bring it back
    push_req(prq_pkg::CMD_BLOCK, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_SCHEDULE, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_SLEEP, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_UNBLOCK, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_UNBLOCK, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_UNBLOCK, 4'd15, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_CREATE, 4'd0, 5'd31, 32'd0);
    push_req(prq_pkg::CMD_CREATE, 4'd0, 5'd0, 32'hFFFF_FFFF);
    push_req(prq_pkg::CMD_CREATE, 4'd0, 5'd31, 32'd0);
    push_req(prq_pkg::CMD_SCHEDULE, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_TICK, 4'd0, 5'd0, 32'd0);
    push_req(3'd6, 4'd0, 5'd0, 32'd0);
    push_req(3'd7, 4'hF, 5'h1F, 32'hFFFF_FFFF);
    wait_idle();
    write_enable(1'b1);

    // Sleep lengths at the extremes and the wrap boundary
    push_req(prq_pkg::CMD_SCHEDULE, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_SLEEP, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_SCHEDULE, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_SLEEP, 4'd0, 5'd0, 32'h8000_0000);
    push_req(prq_pkg::CMD_TICK, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_SCHEDULE, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_SLEEP, 4'd0, 5'd0, 32'hFFFF_FFFF);
    push_req(prq_pkg::CMD_TICK, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_UNBLOCK, 4'd2, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_UNBLOCK, 4'd3, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_SCHEDULE, 4'd0, 5'd0, 32'd0);
    push_req(prq_pkg::CMD_BLOCK, 4'd0, 5'd0, 32'd0);
    wait_idle();

    push_random(500);
    wait_idle();
    write_enable(1'b0);
    push_random(150);
    wait_idle();
    write_enable(1'b1);
    push_random(450);
    wait_idle();
    repeat (40) @(posedge clk);

    if (errors == 0 && expected_outcomes.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/prq_pkg.sv
rtl/prq_alu.sv
rtl/priority_ready_queue_scheduler_core.sv
bench/testbench.sv
